/* hdl/atl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atl_pkg
// Types, widths and calibration tables for the temperature linearizer.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int CAL_POINTS = 36;
    localparam int IDX_W      = $clog2(CAL_POINTS);
    localparam int ADC_W      = 12;
    localparam int HALF_W     = 10;
    localparam int TEMP_W     = 9;
    localparam int ACC_W      = 22;
    localparam int DEN_W      = ADC_W + 1;
    localparam int Q_W        = 10;
    localparam int MCNT_W     = $clog2(ADC_W);
    localparam int QCNT_W     = $clog2(Q_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MAC,
        ST_DIV,
        ST_PUT
    } t_state;

    // one interpolation segment: h = h0 + dx * dh / d, half-degrees
    typedef struct packed {
        logic [HALF_W-1:0] h0;
        logic [HALF_W-1:0] dh;
        logic [ADC_W-1:0]  dx;
        logic [ADC_W-1:0]  d;
    } t_seg;

    function automatic logic [ADC_W-1:0] cal_adc(input logic [IDX_W-1:0] idx);
        logic [ADC_W-1:0] v;
        unique case (idx)
            6'd0:  v = 12'd1040;
            6'd1:  v = 12'd1090;
            6'd2:  v = 12'd1120;
            6'd3:  v = 12'd1150;
            6'd4:  v = 12'd1200;
            6'd5:  v = 12'd1220;
            6'd6:  v = 12'd1240;
            6'd7:  v = 12'd1255;
            6'd8:  v = 12'd1270;
            6'd9:  v = 12'd1300;
            6'd10: v = 12'd1315;
            6'd11: v = 12'd1330;
            6'd12: v = 12'd1360;
            6'd13: v = 12'd1380;
            6'd14: v = 12'd1410;
            6'd15: v = 12'd1480;
            6'd16: v = 12'd1535;
            6'd17: v = 12'd1620;
            6'd18: v = 12'd1660;
            6'd19: v = 12'd1680;
            6'd20: v = 12'd1700;
            6'd21: v = 12'd1720;
            6'd22: v = 12'd1760;
            6'd23: v = 12'd1780;
            6'd24: v = 12'd1790;
            6'd25: v = 12'd1820;
            6'd26: v = 12'd1880;
            6'd27: v = 12'd1900;
            6'd28: v = 12'd1950;
            6'd29: v = 12'd2000;
            6'd30: v = 12'd2070;
            6'd31: v = 12'd2090;
            6'd32: v = 12'd2150;
            6'd33: v = 12'd2175;
            6'd34: v = 12'd2200;
            6'd35: v = 12'd2280;
            default: v = 12'd2280;
        endcase
        return v;
    endfunction

    // temperatures in half-degrees
    function automatic logic [HALF_W-1:0] cal_half(input logic [IDX_W-1:0] idx);
        logic [HALF_W-1:0] v;
        unique case (idx)
            6'd0:  v = 10'd50;
            6'd1:  v = 10'd60;
            6'd2:  v = 10'd72;
            6'd3:  v = 10'd80;
            6'd4:  v = 10'd102;
            6'd5:  v = 10'd114;
            6'd6:  v = 10'd120;
            6'd7:  v = 10'd122;
            6'd8:  v = 10'd128;
            6'd9:  v = 10'd146;
            6'd10: v = 10'd150;
            6'd11: v = 10'd158;
            6'd12: v = 10'd180;
            6'd13: v = 10'd191;
            6'd14: v = 10'd208;
            6'd15: v = 10'd236;
            6'd16: v = 10'd276;
            6'd17: v = 10'd304;
            6'd18: v = 10'd324;
            6'd19: v = 10'd342;
            6'd20: v = 10'd352;
            6'd21: v = 10'd360;
            6'd22: v = 10'd382;
            6'd23: v = 10'd396;
            6'd24: v = 10'd404;
            6'd25: v = 10'd424;
            6'd26: v = 10'd462;
            6'd27: v = 10'd492;
            6'd28: v = 10'd500;
            6'd29: v = 10'd564;
            6'd30: v = 10'd600;
            6'd31: v = 10'd620;
            6'd32: v = 10'd640;
            6'd33: v = 10'd664;
            6'd34: v = 10'd692;
            6'd35: v = 10'd760;
            default: v = 10'd760;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hdl/atl_sample_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atl_sample_if
// Sample channel: valid/ready handshake carrying one converter reading.
// ----------------------------------------------------------------------------
interface atl_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

/* hdl/atl_temp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atl_temp_if
// Result channel: valid/ready handshake carrying one temperature.
// ----------------------------------------------------------------------------
interface atl_temp_if;
    logic       valid;
    logic       ready;
    logic [8:0] temperature_c;

    modport source (output valid, output temperature_c, input ready);
    modport sink   (input valid, input temperature_c, output ready);
endinterface
`default_nettype wire

/* hdl/atl_seg_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atl_seg_search
// Walks the breakpoint table one entry per cycle to find the segment,
// handling both clamp regions as degenerate segments.
// ----------------------------------------------------------------------------
module atl_seg_search (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [11:0]                i_x,
    output logic                      o_done,
    output atl_pkg::t_seg             o_seg
);
    import atl_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAL_POINTS - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ADC_W-1:0]  r_x, n_x;
    t_seg              r_seg, n_seg;

    logic [ADC_W-1:0]  a_lo, a_hi;
    logic [IDX_W-1:0]  idx_hi;

    always_comb begin
        idx_hi = r_idx + IDX_W'(1);
        a_lo   = cal_adc(r_idx);
        a_hi   = cal_adc(idx_hi);
        n_busy = r_busy;
        n_done = 1'b0;
        n_idx  = r_idx;
        n_x    = r_x;
        n_seg  = r_seg;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_x    = i_x;
        end else if (r_busy) begin
            if (r_x <= cal_adc('0)) begin
                // low clamp
                n_seg  = '{h0: cal_half('0), dh: '0, dx: '0, d: ADC_W'(1)};
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_x >= cal_adc(IDX_LAST)) begin
                // high clamp
                n_seg  = '{h0: cal_half(IDX_LAST), dh: '0, dx: '0, d: ADC_W'(1)};
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_x <= a_hi) begin
                n_seg.h0 = cal_half(r_idx);
                n_seg.dh = cal_half(idx_hi) - cal_half(r_idx);
                n_seg.dx = r_x - a_lo;
                n_seg.d  = a_hi - a_lo;
                n_busy   = 1'b0;
                n_done   = 1'b1;
            end else begin
                n_idx = idx_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_idx <= n_idx;
        r_x   <= n_x;
        r_seg <= n_seg;
    end

    assign o_done = r_done;
    assign o_seg  = r_seg;
endmodule
`default_nettype wire

/* hdl/atl_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atl_mac
// Bit-serial multiply-accumulate: h0*d + dx*dh + d, one multiplier bit
// of each product per cycle.
// ----------------------------------------------------------------------------
module atl_mac (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  atl_pkg::t_seg             i_seg,
    output logic                      o_done,
    output logic [21:0]               o_num,
    output logic [12:0]               o_den
);
    import atl_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [MCNT_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  r_mc0, n_mc0;
    logic [ACC_W-1:0]  r_mc1, n_mc1;
    logic [ADC_W-1:0]  r_mp0, n_mp0;
    logic [ADC_W-1:0]  r_mp1, n_mp1;
    logic [DEN_W-1:0]  r_den, n_den;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_mc0  = r_mc0;
        n_mc1  = r_mc1;
        n_mp0  = r_mp0;
        n_mp1  = r_mp1;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = ACC_W'(i_seg.d);
            n_mc0  = ACC_W'(i_seg.h0);
            n_mc1  = ACC_W'(i_seg.dh);
            n_mp0  = i_seg.d;
            n_mp1  = i_seg.dx;
            n_den  = {i_seg.d, 1'b0};
        end else if (r_busy) begin
            n_acc = r_acc + (r_mp0[0] ? r_mc0 : '0) + (r_mp1[0] ? r_mc1 : '0);
            n_mc0 = {r_mc0[ACC_W-2:0], 1'b0};
            n_mc1 = {r_mc1[ACC_W-2:0], 1'b0};
            n_mp0 = {1'b0, r_mp0[ADC_W-1:1]};
            n_mp1 = {1'b0, r_mp1[ADC_W-1:1]};
            n_cnt = r_cnt + MCNT_W'(1);
            if (r_cnt == MCNT_W'(ADC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_mc0 <= n_mc0;
        r_mc1 <= n_mc1;
        r_mp0 <= n_mp0;
        r_mp1 <= n_mp1;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_num  = r_acc;
    assign o_den  = r_den;
endmodule
`default_nettype wire

/* hdl/atl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atl_div
// Restoring divider, one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module atl_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [21:0]                i_num,
    input  wire [12:0]                i_den,
    output logic                      o_done,
    output logic [9:0]                o_quo
);
    import atl_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_rem, n_rem;
    logic [ACC_W-1:0]  r_dsh, n_dsh;
    logic [Q_W-1:0]    r_quo, n_quo;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_dsh  = ACC_W'(i_den) << (Q_W - 1);
            n_quo  = '0;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_quo = {r_quo[Q_W-2:0], 1'b1};
            end else begin
                n_quo = {r_quo[Q_W-2:0], 1'b0};
            end
            n_dsh = {1'b0, r_dsh[ACC_W-1:1]};
            n_cnt = r_cnt + QCNT_W'(1);
            if (r_cnt == QCNT_W'(Q_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

/* hdl/adc_table_temperature_linearizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// flow: after a sample transfer the table walk takes one breakpoint per
// cycle, then serial multiply-accumulate, serial division and handoff
// follow; a new sample is taken only once the last result is in the
// output register; a result waiting in the output register does not
// block the next sample, only the following result
// reset: synchronous active-low i_rst_n clears all control state
// ----------------------------------------------------------------------------
// adc_table_temperature_linearizer_unit
// Piecewise linear calibration of a converter reading into whole degrees.
// ----------------------------------------------------------------------------
module adc_table_temperature_linearizer_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    atl_sample_if.sink i_sample,
    atl_temp_if.source o_temp
);
    import atl_pkg::*;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [TEMP_W-1:0]  r_out_temp, n_out_temp;

    logic               in_xfer;
    logic               srch_done;
    t_seg               seg;
    logic               mac_done;
    logic [ACC_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic               div_done;
    logic [Q_W-1:0]     quo;

    assign in_xfer = i_sample.valid && i_sample.ready;

    atl_seg_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_x     (i_sample.adc_sample),
        .o_done  (srch_done),
        .o_seg   (seg)
    );

    atl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_done),
        .i_seg   (seg),
        .o_done  (mac_done),
        .o_num   (num),
        .o_den   (den)
    );

    atl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_done),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_temp  = r_out_temp;
        if (o_temp.valid && o_temp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (srch_done) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    // saturate to nine bits
                    n_out_temp  = quo[Q_W-1] ? '1 : quo[TEMP_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out_temp <= n_out_temp;
    end

    assign i_sample.ready       = (r_state == ST_IDLE);
    assign o_temp.valid         = r_out_valid;
    assign o_temp.temperature_c = r_out_temp;
endmodule
`default_nettype wire

/* bench/linearizer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linearizer_checker
// Watches the sample and temperature channels of the linearizer. Every
// accepted sample is turned into an expected temperature by an independent
// piecewise linear model of the calibration curve. Every accepted
// temperature is compared in order against the oldest expectation.
// Failures are counted, and the number still outstanding is reported.
// ----------------------------------------------------------------------------
module linearizer_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_sample_valid,
    input  wire        i_sample_ready,
    input  wire [11:0] i_adc_sample,
    input  wire        i_temp_valid,
    input  wire        i_temp_ready,
    input  wire [8:0]  i_temperature_c,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int KNEES = 36;

    localparam bit [11:0] KNEE_ADC [KNEES] = '{
        12'd1040, 12'd1090, 12'd1120, 12'd1150, 12'd1200, 12'd1220, 12'd1240,
        12'd1255, 12'd1270, 12'd1300, 12'd1315, 12'd1330, 12'd1360, 12'd1380,
        12'd1410, 12'd1480, 12'd1535, 12'd1620, 12'd1660, 12'd1680, 12'd1700,
        12'd1720, 12'd1760, 12'd1780, 12'd1790, 12'd1820, 12'd1880, 12'd1900,
        12'd1950, 12'd2000, 12'd2070, 12'd2090, 12'd2150, 12'd2175, 12'd2200,
        12'd2280
    };

    // half-degrees
    localparam bit [9:0] KNEE_HALF [KNEES] = '{
        10'd50,  10'd60,  10'd72,  10'd80,  10'd102, 10'd114, 10'd120,
        10'd122, 10'd128, 10'd146, 10'd150, 10'd158, 10'd180, 10'd191,
        10'd208, 10'd236, 10'd276, 10'd304, 10'd324, 10'd342, 10'd352,
        10'd360, 10'd382, 10'd396, 10'd404, 10'd424, 10'd462, 10'd492,
        10'd500, 10'd564, 10'd600, 10'd620, 10'd640, 10'd664, 10'd692,
        10'd760
    };

    logic [8:0] expected_temps [$];
    logic [8:0] want;

    function automatic logic [8:0] interpolated_temp(input logic [11:0] x);
        longint h0;
        longint h1;
        longint d;
        longint dx;
        longint num;
        longint q;
        bit     found;
        found = 1'b0;
        q = 0;
        if (x <= KNEE_ADC[0]) begin
            q = (longint'(KNEE_HALF[0]) + 1) >>> 1;
        end else if (x >= KNEE_ADC[KNEES-1]) begin
            q = (longint'(KNEE_HALF[KNEES-1]) + 1) >>> 1;
        end else begin
            for (int seg = 0; seg < KNEES - 1; seg++) begin
                if (!found && x >= KNEE_ADC[seg] && x <= KNEE_ADC[seg+1]) begin
                    found = 1'b1;
                    h0  = longint'(KNEE_HALF[seg]);
                    h1  = longint'(KNEE_HALF[seg+1]);
                    d   = longint'(KNEE_ADC[seg+1]) - longint'(KNEE_ADC[seg]);
                    dx  = longint'(x) - longint'(KNEE_ADC[seg]);
                    if (d <= 0) begin
                        q = (h0 + 1) >>> 1;
                    end else begin
                        // rounded half up: (2*h + 2) / 4 in rational form
                        num = 2 * h0 * d + 2 * dx * (h1 - h0) + 2 * d;
                        q = (num <= 0) ? 0 : num / (4 * d);
                    end
                end
            end
            if (!found) begin
                q = (longint'(KNEE_HALF[KNEES-1]) + 1) >>> 1;
            end
        end
        return (q > 511) ? 9'd511 : q[8:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_temps.delete();
            o_fail_count = 0;
        end else begin
            // result transfer first: a sample taken this edge cannot be its source
            if (i_temp_valid && i_temp_ready) begin
                if (expected_temps.size() == 0) begin
                    $error("temperature_c transfer with nothing expected, actual %0d",
                           i_temperature_c);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_temps.pop_front();
                    if (i_temperature_c !== want) begin
                        $error("temperature_c mismatch: expected %0d, actual %0d",
                               want, i_temperature_c);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_sample_valid && i_sample_ready) begin
                expected_temps.push_back(interpolated_temp(i_adc_sample));
            end
        end
        o_pending = expected_temps.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives converter samples into the temperature linearizer: corner samples
// around the clamps and breakpoints first, then random samples weighted
// towards the calibrated span. Both channels idle at random, with one calm
// stretch and one drain pause. The checker beside the block does the
// comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_SAMPLES = 550;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm    = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    logic [11:0] corner_samples [$];

    atl_sample_if sample_ch ();
    atl_temp_if   temp_ch ();

    adc_table_temperature_linearizer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_temp   (temp_ch)
    );

    linearizer_checker checker_u (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample_valid  (sample_ch.valid),
        .i_sample_ready  (sample_ch.ready),
        .i_adc_sample    (sample_ch.adc_sample),
        .i_temp_valid    (temp_ch.valid),
        .i_temp_ready    (temp_ch.ready),
        .i_temperature_c (temp_ch.temperature_c),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        temp_ch.ready = i_rst_n && (calm || $urandom_range(0, 99) >= 23);
    end

    task automatic send_sample(input logic [11:0] x);
        while (!calm && $urandom_range(0, 99) < 23) begin
            sample_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid      = 1'b1;
        sample_ch.adc_sample = x;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [11:0] random_sample();
        int pick;
        int knee;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 12'($urandom_range(1041, 2279));
        end else if (pick < 80) begin
            knee = $urandom_range(0, atl_pkg::CAL_POINTS - 1);
            return 12'(int'(atl_pkg::cal_adc(knee[atl_pkg::IDX_W-1:0]))
                       + int'($urandom_range(0, 2)) - 1);
        end
        return 12'($urandom());
    endfunction

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        temp_ch.ready        = 1'b0;
        corner_samples = '{
            12'h000, 12'hFFF, 12'h800, 12'h7FF, 12'h555, 12'hAAA,
            12'd1039, 12'd1040, 12'd1041, 12'd1065, 12'd1089, 12'd1090,
            12'd1091, 12'd1380, 12'd1381, 12'd1395, 12'd1997, 12'd2000,
            12'd2199, 12'd2200, 12'd2240, 12'd2279, 12'd2280, 12'd2281
        };
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (corner_samples[k]) begin
            send_sample(corner_samples[k]);
        end

        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            calm = (n >= 200 && n < 300);
            if (n == 400) begin
                // drain before carrying on
                sample_ch.valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            send_sample(random_sample());
        end
        sample_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
